// ----- hw/rtl/lswa_pkg.sv -----
// ----------------------------------------------------------------------------
// lswa_pkg: shared types and constants of the LED segment wipe animation
// Register indexes, effect codes, configuration and queue word layouts.
// ----------------------------------------------------------------------------
package lswa_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_SEGMENT_LENGTH = 3'd0;
  localparam logic [2:0] REG_TOTAL_STEPS    = 3'd1;
  localparam logic [2:0] REG_BASE_COLOR     = 3'd2;
  localparam logic [2:0] REG_EFFECT         = 3'd3;
  localparam logic [2:0] REG_INVERT         = 3'd4;
  localparam logic [2:0] REG_AFTERGLOW_Q8   = 3'd5;

  // effect codes
  localparam logic [2:0] EFF_IN_LEFT   = 3'd3;
  localparam logic [2:0] EFF_IN_MIDDLE = 3'd4;
  localparam logic [2:0] EFF_DOT_FLASH = 3'd5;

  localparam int QUEUE_DEPTH = 4;

  // base step of each wipe: out to right, out to left, in to right, in to left
  typedef enum logic [1:0] {
    WB_OUT_RIGHT,
    WB_OUT_LEFT,
    WB_IN_RIGHT,
    WB_IN_LEFT
  } base_t;

  typedef enum logic [1:0] {
    KIND_WIPE,
    KIND_MID,
    KIND_DOT,
    KIND_BLACK
  } kind_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MICRO,
    F_LOAD1,
    F_DIV1,
    F_LOAD2,
    F_DIV2,
    F_PUSH
  } front_state_t;

  typedef struct packed {
    logic [6:0]  seg_len;
    logic [15:0] total;
    logic [23:0] color;
    logic [2:0]  effect;
    logic        invert;
    logic [7:0]  afterglow;
  } cfg_t;

  // one classified step, handed from front to back
  typedef struct packed {
    logic [6:0]  n;
    kind_t       kind;
    logic [6:0]  len;
    logic [18:0] b1;
    logic [18:0] b2;
    logic [8:0]  front1;
    logic [8:0]  front2;
    logic [15:0] micro;
    logic [15:0] dim;
    logic [15:0] mlen;
    logic [23:0] color;
    logic [20:0] dot_num;
    logic [15:0] dot_den;
    logic        dot_flip;
    logic [5:0]  dot_pos;
    logic        dot_two;
  } item_t;

endpackage

// ----- hw/rtl/lswa_front.sv -----
// ----------------------------------------------------------------------------
// lswa_front: step classifier
// Takes one step, works out the wipe geometry with a shared iterative
// divider (micro step and the wipe fronts) and pushes one queue word,
// unless the segment length is 0.
module lswa_front #(
  parameter int MAX_LEDS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [17:0]       in_step,
  input  lswa_pkg::cfg_t    cfg,
  input  logic              q_full,
  output logic              take,
  output logic              push,
  output lswa_pkg::item_t   item
);

  lswa_pkg::front_state_t state, state_next;

  // decode of a new step
  logic [6:0]          n_new, len_new;
  logic [15:0]         t_new, h_new;
  logic [14:0]         tail_prod;
  logic [7:0]          span_new;
  logic signed [18:0]  s_new, t19, h19;
  lswa_pkg::kind_t     kind_new;
  logic [1:0]          inv2;
  logic signed [18:0]  b1_new, b2_new;
  logic signed [20:0]  dnum_new;
  logic [15:0]         dden_new;
  logic                dflip_new;

  // held step
  logic [6:0]          n, len;
  lswa_pkg::kind_t     kind;
  logic [15:0]         t;
  logic [6:0]          tail;
  logic [7:0]          span;
  logic [18:0]         b1, b2;
  logic [23:0]         color;
  logic [20:0]         dot_num;
  logic [15:0]         dot_den;
  logic                dot_flip;
  logic [5:0]          dot_pos;
  logic                dot_two;
  logic [15:0]         micro;
  logic [8:0]          front1, front2;

  // divider
  logic [24:0]         rem;
  logic [15:0]         dvs;
  logic [3:0]          k;
  logic [15:0]         q;
  logic                neg;
  logic [30:0]         dshift;
  logic                dge;
  logic [24:0]         rem_sub;
  logic [15:0]         q_new;
  logic                fsat;
  logic                fdone;
  logic [7:0]          fmag;
  logic [8:0]          fval;
  logic signed [18:0]  bsel;
  logic signed [27:0]  prod;
  logic [27:0]         prod_mag;
  logic [22:0]         dim_prod, mlen_prod;

  function automatic logic signed [18:0] wipe_base(input lswa_pkg::base_t bk,
                                                   input logic signed [18:0] s,
                                                   input logic signed [18:0] tt);
    unique case (bk)
      lswa_pkg::WB_OUT_RIGHT: wipe_base = s;
      lswa_pkg::WB_OUT_LEFT:  wipe_base = -s;
      lswa_pkg::WB_IN_RIGHT:  wipe_base = s - tt;
      lswa_pkg::WB_IN_LEFT:   wipe_base = tt - s;
      default:                wipe_base = s;
    endcase
  endfunction

  always_comb begin
    n_new = (cfg.seg_len > 7'(MAX_LEDS)) ? 7'(MAX_LEDS) : cfg.seg_len;
    t_new = (cfg.total < 16'd2) ? 16'd2 : cfg.total;
    len_new = (cfg.effect == lswa_pkg::EFF_IN_MIDDLE) ? (n_new >> 1) : n_new;
    tail_prod = 15'(len_new) * 15'(cfg.afterglow);
    span_new = {1'b0, len_new} + {1'b0, tail_prod[14:8]};
    s_new = $signed({in_step[17], in_step});
    t19 = $signed({3'b000, t_new});
    h_new = t_new >> 1;
    h19 = $signed({3'b000, h_new});
    inv2 = {1'b0, cfg.invert};

    priority if (cfg.effect <= lswa_pkg::EFF_IN_LEFT) begin
      kind_new = lswa_pkg::KIND_WIPE;
    end else if (cfg.effect == lswa_pkg::EFF_IN_MIDDLE) begin
      kind_new = (len_new == 7'd0) ? lswa_pkg::KIND_BLACK : lswa_pkg::KIND_MID;
    end else if (cfg.effect == lswa_pkg::EFF_DOT_FLASH) begin
      kind_new = lswa_pkg::KIND_DOT;
    end else begin
      kind_new = lswa_pkg::KIND_BLACK;
    end

    if (kind_new == lswa_pkg::KIND_MID) begin
      b1_new = wipe_base(lswa_pkg::base_t'(2'(lswa_pkg::WB_IN_RIGHT) ^ inv2), s_new, t19);
      b2_new = wipe_base(lswa_pkg::base_t'(2'(lswa_pkg::WB_IN_LEFT) ^ inv2), s_new, t19);
    end else begin
      b1_new = wipe_base(lswa_pkg::base_t'(cfg.effect[1:0] ^ inv2), s_new, t19);
      b2_new = b1_new;
    end

    // dot flash: rising half fades in to full, falling half fades out
    if (s_new < h19) begin
      dnum_new = 21'(s_new);
      dden_new = h_new;
      dflip_new = 1'b1;
    end else begin
      dnum_new = 21'(s_new - h19);
      dden_new = t_new - h_new;
      dflip_new = 1'b0;
    end
  end

  // shared restoring divider, one quotient bit a cycle
  always_comb begin
    dshift = {15'd0, dvs} << k;
    dge = {6'd0, rem} >= dshift;
    rem_sub = rem - dshift[24:0];
    q_new = dge ? (q | (16'd1 << k)) : q;
    // a front beyond 127 LEDs only matters as "far away"
    fsat = (state == lswa_pkg::F_DIV1 || state == lswa_pkg::F_DIV2) && (k == 4'd7) && dge;
    fdone = fsat || (k == 4'd0);
    fmag = fsat ? 8'd128 : q_new[7:0];
    fval = neg ? (9'd0 - {1'b0, fmag}) : {1'b0, fmag};
    bsel = (state == lswa_pkg::F_LOAD2) ? $signed(b2) : $signed(b1);
    prod = 28'(bsel) * $signed({20'd0, 8'(span + 8'd1)});
    prod_mag = prod[27] ? (28'd0 - prod) : prod;
    dim_prod = 23'(micro) * 23'(tail);
    mlen_prod = 23'(micro) * 23'(len);
  end

  always_comb begin
    state_next = state;
    take = 1'b0;
    push = 1'b0;
    unique case (state)
      lswa_pkg::F_IDLE: begin
        take = in_valid;
        if (in_valid && n_new != 7'd0) begin
          if (kind_new == lswa_pkg::KIND_WIPE || kind_new == lswa_pkg::KIND_MID) begin
            state_next = lswa_pkg::F_MICRO;
          end else begin
            state_next = lswa_pkg::F_PUSH;
          end
        end
      end
      lswa_pkg::F_MICRO: begin
        if (k == 4'd0) begin
          state_next = lswa_pkg::F_LOAD1;
        end
      end
      lswa_pkg::F_LOAD1: state_next = lswa_pkg::F_DIV1;
      lswa_pkg::F_DIV1: begin
        if (fdone) begin
          state_next = (kind == lswa_pkg::KIND_MID) ? lswa_pkg::F_LOAD2 : lswa_pkg::F_PUSH;
        end
      end
      lswa_pkg::F_LOAD2: state_next = lswa_pkg::F_DIV2;
      lswa_pkg::F_DIV2: begin
        if (fdone) begin
          state_next = lswa_pkg::F_PUSH;
        end
      end
      lswa_pkg::F_PUSH: begin
        push = !q_full;
        if (!q_full) begin
          state_next = lswa_pkg::F_IDLE;
        end
      end
      default: state_next = lswa_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lswa_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      lswa_pkg::F_IDLE: begin
        if (in_valid) begin
          n <= n_new;
          len <= len_new;
          kind <= kind_new;
          t <= t_new;
          tail <= tail_prod[14:8];
          span <= span_new;
          b1 <= b1_new;
          b2 <= b2_new;
          color <= cfg.color;
          dot_num <= dnum_new;
          dot_den <= dden_new;
          dot_flip <= dflip_new;
          dot_pos <= 6'((n_new - 7'd1) >> 1);
          dot_two <= ~n_new[0];
          rem <= {9'd0, t_new};
          dvs <= {8'd0, span_new};
          k <= 4'd15;
          q <= '0;
        end
      end
      lswa_pkg::F_MICRO: begin
        if (dge) begin
          rem <= rem_sub;
        end
        q <= q_new;
        k <= k - 4'd1;
        if (k == 4'd0) begin
          micro <= q_new;
        end
      end
      lswa_pkg::F_LOAD1, lswa_pkg::F_LOAD2: begin
        rem <= prod_mag[24:0];
        neg <= prod[27];
        dvs <= t;
        k <= 4'd7;
        q <= '0;
      end
      lswa_pkg::F_DIV1: begin
        if (dge) begin
          rem <= rem_sub;
        end
        q <= q_new;
        k <= k - 4'd1;
        if (fdone) begin
          front1 <= fval;
        end
      end
      lswa_pkg::F_DIV2: begin
        if (dge) begin
          rem <= rem_sub;
        end
        q <= q_new;
        k <= k - 4'd1;
        if (fdone) begin
          front2 <= fval;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    item.n = n;
    item.kind = kind;
    item.len = len;
    item.b1 = b1;
    item.b2 = b2;
    item.front1 = front1;
    item.front2 = front2;
    item.micro = micro;
    item.dim = dim_prod[15:0];
    item.mlen = mlen_prod[15:0];
    item.color = color;
    item.dot_num = dot_num;
    item.dot_den = dot_den;
    item.dot_flip = dot_flip;
    item.dot_pos = dot_pos;
    item.dot_two = dot_two;
  end

endmodule

// ----- hw/rtl/lswa_queue.sv -----
// ----------------------------------------------------------------------------
// lswa_queue: step queue
// Short FIFO of classified steps between the classifier and the LED engine.
// ----------------------------------------------------------------------------
module lswa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lswa_pkg::item_t din,
  input  logic            pop,
  output lswa_pkg::item_t dout,
  output logic            full,
  output logic            empty
);

  localparam int DEPTH = lswa_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  lswa_pkg::item_t  words [DEPTH];
  logic [PTR_W-1:0] wr, rd;
  logic [PTR_W:0]   count;
  logic             do_push, do_pop;

  assign full = count == (PTR_W + 1)'(DEPTH);
  assign empty = count == '0;
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = words[rd];

  always_ff @(posedge clk) begin
    if (do_push) begin
      words[wr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr <= wr + 1'b1;
      end
      if (do_pop) begin
        rd <= rd + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/lswa_back.sv -----
// ----------------------------------------------------------------------------
// lswa_back: LED engine
// Walks the LEDs of the queue head one a cycle and runs each through a
// classify stage, an 8-stage fade divider and the colour scaler.
// ----------------------------------------------------------------------------
module lswa_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  lswa_pkg::item_t head,
  output logic            pop,
  output logic            strobe,
  output logic [5:0]      led_index,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue,
  output logic            last
);

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_BLACK,
    MODE_FADE
  } mode_t;

  typedef struct packed {
    logic [5:0]  idx;
    logic        last;
    logic        wipe;
    logic        dot;
    logic [6:0]  j;
    logic [18:0] b;
    logic [8:0]  front;
    logic [6:0]  len;
    logic [15:0] start;
    logic [15:0] mlen;
    logic [15:0] dim;
    logic [20:0] dot_num;
    logic [15:0] dot_den;
    logic        dot_flip;
    logic [23:0] color;
  } s0_t;

  typedef struct packed {
    logic [5:0]  idx;
    logic        last;
    logic [23:0] color;
    mode_t       mode;
    logic [20:0] num;
    logic [15:0] den;
    logic        flip;
  } cls_t;

  typedef struct packed {
    logic [5:0]  idx;
    logic        last;
    logic [23:0] color;
    logic        black;
    logic        flip;
    logic        fixed;
    logic [7:0]  fixv;
    logic [23:0] rem;
    logic [15:0] den;
    logic [7:0]  q;
  } div_t;

  // LED sequencer
  logic [5:0]  i;
  logic [6:0]  i7, j_sel;
  logic        issue, last_led, in_wipe, sel2, dot_hit;
  logic [22:0] start_prod;

  s0_t         s0;
  logic        s0_valid;
  cls_t        c1, c1_next;
  logic        c1_valid;
  div_t        dv [9];
  div_t        dv_n [8];
  logic [8:0]  dv_valid;
  div_t        pre;

  always_comb begin
    issue = !q_empty;
    i7 = {1'b0, i};
    last_led = i7 == (head.n - 7'd1);
    in_wipe = 1'b0;
    sel2 = 1'b0;
    j_sel = i7;
    dot_hit = 1'b0;
    unique case (head.kind)
      lswa_pkg::KIND_WIPE: in_wipe = 1'b1;
      lswa_pkg::KIND_MID: begin
        if (i7 < head.len) begin
          in_wipe = 1'b1;
        end else if ({1'b0, i7} < {head.len, 1'b0}) begin
          in_wipe = 1'b1;
          sel2 = 1'b1;
          j_sel = i7 - head.len;
        end
      end
      lswa_pkg::KIND_DOT: begin
        dot_hit = (i == head.dot_pos) ||
                  (head.dot_two && i7 == ({1'b0, head.dot_pos} + 7'd1));
      end
      default: ;
    endcase
    start_prod = 23'(head.micro) * 23'(j_sel);
    pop = issue && last_led;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= issue;
      if (issue) begin
        i <= last_led ? 6'd0 : i + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s0.idx <= i;
    s0.last <= last_led;
    s0.wipe <= in_wipe;
    s0.dot <= dot_hit;
    s0.j <= j_sel;
    s0.b <= sel2 ? head.b2 : head.b1;
    s0.front <= sel2 ? head.front2 : head.front1;
    s0.len <= head.len;
    s0.start <= start_prod[15:0];
    s0.mlen <= head.mlen;
    s0.dim <= head.dim;
    s0.dot_num <= head.dot_num;
    s0.dot_den <= head.dot_den;
    s0.dot_flip <= head.dot_flip;
    s0.color <= head.color;
  end

  // classify against the wipe front
  logic signed [9:0]  f10, fl, jj;
  logic signed [20:0] bx, behind_num, ahead_num;

  always_comb begin
    f10 = $signed({s0.front[8], s0.front});
    fl = f10 + $signed({3'b000, s0.len});
    jj = $signed({3'b000, s0.j});
    bx = $signed({{2{s0.b[18]}}, s0.b});
    behind_num = bx - $signed({5'd0, s0.start});
    ahead_num = $signed({5'd0, s0.start}) - $signed({5'd0, s0.mlen}) - bx;
    c1_next.idx = s0.idx;
    c1_next.last = s0.last;
    c1_next.color = s0.color;
    c1_next.mode = MODE_BLACK;
    c1_next.num = '0;
    c1_next.den = s0.dim;
    c1_next.flip = 1'b0;
    if (s0.wipe) begin
      if (f10 <= jj && fl > jj) begin
        c1_next.mode = MODE_ZERO;
      end else if (jj < fl) begin
        c1_next.num = behind_num;
        c1_next.mode = behind_num[20] ? MODE_ZERO : MODE_FADE;
      end else begin
        c1_next.num = ahead_num;
        c1_next.mode = ahead_num[20] ? MODE_ZERO : MODE_FADE;
      end
    end else if (s0.dot) begin
      c1_next.mode = MODE_FADE;
      c1_next.num = s0.dot_num;
      c1_next.den = s0.dot_den;
      c1_next.flip = s0.dot_flip;
    end
  end

  always_ff @(posedge clk) begin
    c1 <= c1_next;
  end

  // settle the saturated cases, else set up num * 255 for the divider
  always_comb begin
    pre.idx = c1.idx;
    pre.last = c1.last;
    pre.color = c1.color;
    pre.black = 1'b0;
    pre.flip = c1.flip;
    pre.fixed = 1'b1;
    pre.fixv = 8'd0;
    pre.rem = ({8'd0, c1.num[15:0]} << 8) - {8'd0, c1.num[15:0]};
    pre.den = c1.den;
    pre.q = 8'd0;
    unique case (c1.mode)
      MODE_BLACK: pre.black = 1'b1;
      MODE_FADE: begin
        priority if (c1.den == 16'd0) begin
          pre.fixv = 8'd255;
        end else if (c1.num[20] || c1.num == 21'd0) begin
          pre.fixv = 8'd0;
        end else if ($signed(c1.num) >= $signed({5'd0, c1.den})) begin
          pre.fixv = 8'd255;
        end else begin
          pre.fixed = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
      dv_valid <= '0;
    end else begin
      c1_valid <= s0_valid;
      dv_valid <= {dv_valid[7:0], c1_valid};
    end
  end

  // one quotient bit per stage, most significant first
  always_comb begin
    for (int g = 0; g < 8; g++) begin
      dv_n[g] = dv[g];
      if (dv[g].rem >= ({8'd0, dv[g].den} << (7 - g))) begin
        dv_n[g].rem = dv[g].rem - ({8'd0, dv[g].den} << (7 - g));
        dv_n[g].q[3'(7 - g)] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dv[0] <= pre;
    for (int g = 0; g < 8; g++) begin
      dv[g + 1] <= dv_n[g];
    end
  end

  // scale the colour
  logic [7:0]  d_raw, d;
  logic [8:0]  keep;
  logic [16:0] pr, pg, pb;

  always_comb begin
    d_raw = dv[8].fixed ? dv[8].fixv : dv[8].q;
    d = dv[8].flip ? (8'd255 - d_raw) : d_raw;
    keep = 9'd256 - {1'b0, d};
    pr = 17'(dv[8].color[23:16]) * 17'(keep);
    pg = 17'(dv[8].color[15:8]) * 17'(keep);
    pb = 17'(dv[8].color[7:0]) * 17'(keep);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= dv_valid[8];
    end
  end

  always_ff @(posedge clk) begin
    led_index <= dv[8].idx;
    last <= dv[8].last;
    red <= dv[8].black ? 8'd0 : pr[15:8];
    green <= dv[8].black ? 8'd0 : pg[15:8];
    blue <= dv[8].black ? 8'd0 : pb[15:8];
  end

endmodule

// ----- hw/rtl/led_segment_wipe_animation.sv -----
// ----------------------------------------------------------------------------
// led_segment_wipe_animation: LED segment wipe animation top level
// Turns an animation step into one colour word per LED of the segment.
// ----------------------------------------------------------------------------
// Usage:
//   Write the six registers through cfg_we / cfg_index / cfg_wdata while the
//   block is idle. Present a step with start; it is taken on a clock edge
//   where start is high and busy is low. busy rises for the cycle after a
//   take and drops as soon as the classifier picks the step up.
//   For each step the block emits segment_length words (capped at MAX_LEDS),
//   LED 0 first, one per cycle on strobe, with last set on the final LED.
//   A segment length of 0 emits nothing. Words cannot be held off.
// Timing:
//   The classifier pushes a dot flash or black step without the divider; a
//   wipe or in-to-middle step first runs its serial divider (one quotient
//   bit a cycle) for the micro step and one or both fronts. The LED engine
//   emits one LED per cycle while the queue holds a step; the classifier can
//   meanwhile take the next step if the queue has room. A step's first word
//   passes the sequencer, classify, divider and output registers.
//   Reset clears the registers to their defaults and empties the pipeline.
// ----------------------------------------------------------------------------
module led_segment_wipe_animation #(
  parameter int MAX_LEDS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [17:0] step,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata,
  output logic               strobe,
  output logic [5:0]         led_index,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic               last
);

  lswa_pkg::cfg_t  cfg;
  logic            in_valid;
  logic [17:0]     in_step;
  logic            take;
  logic            q_push, q_pop, q_full, q_empty;
  lswa_pkg::item_t q_din, q_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seg_len <= 7'd1;
      cfg.total <= 16'd100;
      cfg.color <= 24'hFFFFFF;
      cfg.effect <= 3'd0;
      cfg.invert <= 1'b0;
      cfg.afterglow <= 8'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lswa_pkg::REG_SEGMENT_LENGTH: cfg.seg_len <= cfg_wdata[6:0];
        lswa_pkg::REG_TOTAL_STEPS:    cfg.total <= cfg_wdata[15:0];
        lswa_pkg::REG_BASE_COLOR:     cfg.color <= cfg_wdata;
        lswa_pkg::REG_EFFECT:         cfg.effect <= cfg_wdata[2:0];
        lswa_pkg::REG_INVERT:         cfg.invert <= cfg_wdata[0];
        lswa_pkg::REG_AFTERGLOW_Q8:   cfg.afterglow <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // one-word input buffer
  assign busy = in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (start && !in_valid) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !in_valid) begin
      in_step <= step;
    end
  end

  lswa_front #(
    .MAX_LEDS(MAX_LEDS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_step(in_step),
    .cfg(cfg),
    .q_full(q_full),
    .take(take),
    .push(q_push),
    .item(q_din)
  );

  lswa_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .din(q_din),
    .pop(q_pop),
    .dout(q_dout),
    .full(q_full),
    .empty(q_empty)
  );

  lswa_back u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .head(q_dout),
    .pop(q_pop),
    .strobe(strobe),
    .led_index(led_index),
    .red(red),
    .green(green),
    .blue(blue),
    .last(last)
  );

`ifndef SYNTHESIS
  a_led_run: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe && led_index == $past(led_index) + 6'd1)
    else $error("LED words of one step are not contiguous");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("step queue written while full");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("taken step not held in input buffer");
`endif

endmodule
